@@ rtl/core/ipg_pkg.sv @@
// Integer partition generator: shared types and constants.
// Used by the result channel interface, the top level and the checker.
package ipg_pkg;

    localparam int VAL_W      = 7;   // part values and counts
    localparam int IDX_W      = 6;   // part position on the result channel
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PARTITION_TOTAL = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_FIRST_PART  = 1'd1;

    localparam logic [VAL_W-1:0] TOTAL_RST = 7'd8;
    localparam logic [VAL_W-1:0] MIN_RST   = 7'd0;

    typedef enum logic [STATUS_W-1:0] {
        ST_PART  = 2'd0,
        ST_DONE  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

endpackage

@@ rtl/core/ipg_in_if.sv @@
// Input channel of the integer partition generator: one restart/advance request.
// Depends on nothing but the handshake convention (valid/ready).
interface ipg_in_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

@@ rtl/core/ipg_out_if.sv @@
// Result channel of the integer partition generator: one part or status word.
// Depends on ipg_pkg for widths and the status type.
interface ipg_out_if;
    logic                      valid;
    logic                      ready;
    logic [ipg_pkg::VAL_W-1:0] part_value;
    logic [ipg_pkg::IDX_W-1:0] part_index;
    ipg_pkg::status_t          status;
    logic                      last;

    modport source (output valid, output part_value, output part_index, output status,
                     output last, input ready);
    modport sink   (input valid, input part_value, input part_index, input status,
                    input last, output ready);
endinterface

@@ rtl/core/integer_partition_generator_top.sv @@
// Integer partition generator (ZS1 order): sequencer, part memory, output register.
// Depends on ipg_pkg, ipg_in_if and ipg_out_if.
//
// Usage:
//   in_ch carries one request per transfer: restart=1 loads the single-part
//   partition of partition_total (saturated to MAX_TOTAL), restart=0 steps to
//   the next partition. out_ch then returns the parts largest first, one per
//   transfer, last set on the final part; or a single finished / empty status
//   word (value 0, index 0, last 1).
//   Config: cfg_we writes cfg_wdata to register cfg_index; write only when idle.
// Timing:
//   in_ch.ready is high only in the idle state. A restart writes the total at
//   the transfer, fills the other MAX_TOTAL-1 entries with ones, one per cycle,
//   primes the read and sends its single part.
//   An advance lowers the part at the rightmost index above one; unless that
//   part was two, it then peels copies of the new value off the remainder one
//   at a time and writes any rest above one. It then checks the bound, primes
//   the read and emits the parts.
//   A stalled out_ch holds the output register; the sequencer waits in the
//   emit or status state, and a new request may be taken while the last word
//   of the previous one still waits.
// Reset: the block is idle and inactive; an advance reports finished until
//   a restart. Registers return to total 8, bound 0.
module integer_partition_generator_top #(
    parameter int MAX_TOTAL = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [ipg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ipg_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    ipg_in_if.sink                             in_ch,
    ipg_out_if.source                          out_ch
);
    import ipg_pkg::*;

    localparam int IW = (MAX_TOTAL > 1) ? $clog2(MAX_TOTAL) : 1;
    localparam logic [VAL_W-1:0] MAX_VAL  = VAL_W'(MAX_TOTAL);
    localparam logic [IW-1:0]    LAST_IDX = IW'(MAX_TOTAL - 1);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_FILL   = 8'b0000_0010,
        S_STEP   = 8'b0000_0100,
        S_LOOP   = 8'b0000_1000,
        S_CHECK  = 8'b0001_0000,
        S_PRIME  = 8'b0010_0000,
        S_EMIT   = 8'b0100_0000,
        S_STATUS = 8'b1000_0000
    } state_t;

    state_t             state_reg, state_next;
    logic [VAL_W-1:0]   total_reg, total_next;
    logic [VAL_W-1:0]   min_reg, min_next;
    logic [VAL_W-1:0]   p0_reg, p0_next;      // copy of the first part
    logic [VAL_W-1:0]   cnt_reg, cnt_next;
    logic [IW-1:0]      rbi_reg, rbi_next;
    logic               active_reg, active_next;
    logic [IW-1:0]      j_reg, j_next;        // working index, also fill/emit index
    logic [VAL_W-1:0]   t_reg, t_next;
    logic [VAL_W-1:0]   r_reg, r_next;
    status_t            st_reg, st_next;

    logic               out_valid_reg, out_valid_next;
    logic [VAL_W-1:0]   out_value_reg;
    logic [IDX_W-1:0]   out_index_reg;
    status_t            out_status_reg;
    logic               out_last_reg;

    logic [VAL_W-1:0]   mem [MAX_TOTAL];
    logic [VAL_W-1:0]   rdata_reg;
    logic               mem_we;
    logic [IW-1:0]      mem_waddr;
    logic [VAL_W-1:0]   mem_wdata;
    logic [IW-1:0]      rd_addr;

    logic               load;
    logic [VAL_W-1:0]   ld_value;
    logic [IDX_W-1:0]   ld_index;
    status_t            ld_status;
    logic               ld_last;

    logic               out_free;
    logic [VAL_W-1:0]   n_sat;
    logic [VAL_W-1:0]   t_cur;
    logic [IW-1:0]      j_inc;
    logic [VAL_W-1:0]   j_ext;
    logic [VAL_W-1:0]   rbi_ext;

    assign out_free = !out_valid_reg || out_ch.ready;
    assign n_sat    = (total_reg > MAX_VAL) ? MAX_VAL : total_reg;
    assign t_cur    = rdata_reg - VAL_W'(1);
    assign j_inc    = j_reg + IW'(1);
    assign j_ext    = VAL_W'(j_reg);
    assign rbi_ext  = VAL_W'(rbi_reg);

    assign in_ch.ready       = (state_reg == S_IDLE);
    assign out_ch.valid      = out_valid_reg;
    assign out_ch.part_value = out_value_reg;
    assign out_ch.part_index = out_index_reg;
    assign out_ch.status     = out_status_reg;
    assign out_ch.last       = out_last_reg;

    always_comb
    begin
        state_next  = state_reg;
        total_next  = total_reg;
        min_next    = min_reg;
        p0_next     = p0_reg;
        cnt_next    = cnt_reg;
        rbi_next    = rbi_reg;
        active_next = active_reg;
        j_next      = j_reg;
        t_next      = t_reg;
        r_next      = r_reg;
        st_next     = st_reg;
        mem_we      = 1'b0;
        mem_waddr   = j_reg;
        mem_wdata   = '0;
        rd_addr     = j_reg;
        load        = 1'b0;
        ld_value    = '0;
        ld_index    = '0;
        ld_status   = ST_PART;
        ld_last     = 1'b1;

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_PARTITION_TOTAL: total_next = cfg_wdata;
                CFG_MIN_FIRST_PART:  min_next   = cfg_wdata;
                default:             ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                rd_addr = rbi_reg;
                if (in_ch.valid)
                begin
                    if (in_ch.restart)
                    begin
                        rbi_next = '0;
                        if (n_sat == '0)
                        begin
                            cnt_next    = '0;
                            active_next = 1'b0;
                            st_next     = ST_EMPTY;
                            state_next  = S_STATUS;
                        end
                        else
                        begin
                            mem_we      = 1'b1;
                            mem_waddr   = '0;
                            mem_wdata   = n_sat;
                            p0_next     = n_sat;
                            cnt_next    = VAL_W'(1);
                            active_next = 1'b1;
                            j_next      = IW'(1);
                            state_next  = (MAX_TOTAL > 1) ? S_FILL : S_PRIME;
                        end
                    end
                    else if (!active_reg || p0_reg <= VAL_W'(1))
                    begin
                        active_next = 1'b0;
                        rbi_next    = '0;
                        st_next     = ST_DONE;
                        state_next  = S_STATUS;
                    end
                    else
                    begin
                        state_next = S_STEP;
                    end
                end
            end

            S_FILL:
            begin
                mem_we    = 1'b1;
                mem_waddr = j_reg;
                mem_wdata = VAL_W'(1);
                if (j_reg == LAST_IDX)
                    state_next = S_PRIME;
                else
                    j_next = j_inc;
            end

            S_STEP:
            begin
                // rdata_reg holds the part at the rightmost index above one
                mem_we    = 1'b1;
                mem_waddr = rbi_reg;
                if (rdata_reg == VAL_W'(2))
                begin
                    mem_wdata = VAL_W'(1);
                    if (rbi_reg == '0)
                        p0_next = VAL_W'(1);
                    rbi_next   = (rbi_reg != '0) ? rbi_reg - IW'(1) : '0;
                    cnt_next   = (cnt_reg < MAX_VAL) ? cnt_reg + VAL_W'(1) : cnt_reg;
                    state_next = S_CHECK;
                end
                else
                begin
                    mem_wdata = t_cur;
                    if (rbi_reg == '0)
                        p0_next = t_cur;
                    t_next     = t_cur;
                    r_next     = (cnt_reg > rbi_ext) ? cnt_reg - rbi_ext : '0;
                    j_next     = rbi_reg;
                    state_next = S_LOOP;
                end
            end

            S_LOOP:
            begin
                // shared compare/subtract: peel one copy of t off the remainder
                if (t_reg != '0 && r_reg > t_reg && j_reg != LAST_IDX)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = j_inc;
                    mem_wdata = t_reg;
                    j_next    = j_inc;
                    r_next    = r_reg - t_reg;
                end
                else
                begin
                    cnt_next = (j_reg == LAST_IDX) ? MAX_VAL : j_ext + VAL_W'(2);
                    if (r_reg > VAL_W'(1) && j_reg != LAST_IDX)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = j_inc;
                        mem_wdata = r_reg;
                        rbi_next  = j_inc;
                    end
                    else
                    begin
                        rbi_next = j_reg;
                    end
                    state_next = S_CHECK;
                end
            end

            S_CHECK:
            begin
                if ((min_reg != '0 && p0_reg < min_reg) || cnt_reg == '0)
                begin
                    active_next = 1'b0;
                    rbi_next    = '0;
                    st_next     = ST_DONE;
                    state_next  = S_STATUS;
                end
                else
                begin
                    state_next = S_PRIME;
                end
            end

            S_PRIME:
            begin
                rd_addr    = '0;
                j_next     = '0;
                state_next = S_EMIT;
            end

            S_EMIT:
            begin
                // rdata_reg always holds the part at j_reg here
                if (out_free)
                begin
                    load      = 1'b1;
                    ld_value  = rdata_reg;
                    ld_index  = IDX_W'(j_reg);
                    ld_status = ST_PART;
                    ld_last   = (j_ext + VAL_W'(1) == cnt_reg);
                    if (ld_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        j_next  = j_inc;
                        rd_addr = j_inc;
                    end
                end
            end

            S_STATUS:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    ld_status  = st_reg;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (load)
            out_valid_next = 1'b1;
        else if (out_ch.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            total_reg     <= TOTAL_RST;
            min_reg       <= MIN_RST;
            p0_reg        <= '0;
            cnt_reg       <= '0;
            rbi_reg       <= '0;
            active_reg    <= 1'b0;
            j_reg         <= '0;
            st_reg        <= ST_DONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            min_reg       <= min_next;
            p0_reg        <= p0_next;
            cnt_reg       <= cnt_next;
            rbi_reg       <= rbi_next;
            active_reg    <= active_next;
            j_reg         <= j_next;
            st_reg        <= st_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg <= t_next;
        r_reg <= r_next;
        if (load)
        begin
            out_value_reg  <= ld_value;
            out_index_reg  <= ld_index;
            out_status_reg <= ld_status;
            out_last_reg   <= ld_last;
        end
    end

    // part memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rdata_reg <= mem[rd_addr];
    end

endmodule

@@ rtl/core/ipg_checker.sv @@
// Port-level checks for the integer partition generator, bound to the top level.
// Depends on ipg_pkg and integer_partition_generator_top.
module ipg_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic [ipg_pkg::VAL_W-1:0] part_value,
    input logic [ipg_pkg::IDX_W-1:0] part_index,
    input ipg_pkg::status_t          status,
    input logic                      last
);
    import ipg_pkg::*;

    // one request at a time: busy right after a request transfer
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("ipg: ready right after a request transfer");

    // status words are single, final and carry no part
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_PART) |-> (last && part_value == '0 && part_index == '0))
        else $error("ipg: malformed status word");

    // more parts pending keeps the input side closed
    a_parts_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_PART && !last) |-> !in_ready)
        else $error("ipg: ready while parts of a partition are pending");

    // the first part of a partition is never zero
    a_first_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_PART && part_index == '0) |-> part_value != '0)
        else $error("ipg: zero leading part");

endmodule

bind integer_partition_generator_top ipg_checker u_ipg_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .part_value (out_ch.part_value),
    .part_index (out_ch.part_index),
    .status     (out_ch.status),
    .last       (out_ch.last)
);
